// ===== sv/mtm_pkg.sv =====
// Shared types, codes and the controller table of the score-to-MIDI transcoder.
package mtm_pkg;

	localparam int CH_COUNT    = 16;
	localparam int CH_W        = 4;
	localparam int DELTA_W_DEF = 28;
	localparam int DELTA_W_MAX = 28;

	// parser position inside one score event
	typedef enum logic [2:0] {
		PH_EVENT,
		PH_DATA1,
		PH_VOLUME,
		PH_DATA2,
		PH_DELAY
	} phase_t;

	// emitter position inside one output event
	typedef enum logic [1:0] {
		SQ_DELTA,
		SQ_SETUP,
		SQ_MSG
	} seq_t;

	// score event types (bits 6..4 of the event byte)
	localparam logic [2:0] EV_NOTE_OFF = 3'd0;
	localparam logic [2:0] EV_NOTE_ON  = 3'd1;
	localparam logic [2:0] EV_BEND     = 3'd2;
	localparam logic [2:0] EV_MODE     = 3'd3;
	localparam logic [2:0] EV_CTRL     = 3'd4;
	localparam logic [2:0] EV_SKIP_A   = 3'd5;
	localparam logic [2:0] EV_END      = 3'd6;
	localparam logic [2:0] EV_SKIP_B   = 3'd7;

	// MIDI status and data constants
	localparam logic [7:0] ST_NOTE_OFF = 8'h80;
	localparam logic [7:0] ST_NOTE_ON  = 8'h90;
	localparam logic [7:0] ST_BEND     = 8'hE0;
	localparam logic [7:0] ST_CTRL     = 8'hB0;
	localparam logic [7:0] ST_PROG     = 8'hC0;
	localparam logic [7:0] ST_META     = 8'hFF;
	localparam logic [6:0] META_EOT    = 7'h2F;
	localparam logic [6:0] OFF_VEL     = 7'h40;
	localparam logic [6:0] CC_VOLUME   = 7'h07;
	localparam logic [6:0] VOL_FULL    = 7'h7F;
	localparam logic [6:0] VOL_RESET   = 7'd64;
	localparam logic [7:0] CTL_LAST    = 8'd14;
	localparam logic [7:0] CTL_MONO    = 8'd12;
	localparam logic [3:0] PERC_CH     = 4'd9;
	localparam logic [3:0] PERC_SRC    = 4'd15;
	localparam logic [4:0] SKIP_CH     = 5'd9;
	localparam logic [4:0] CH_LIMIT    = 5'd16;

	typedef struct packed {
		logic [DELTA_W_MAX-1:0] delta;
		logic                   setup;
		logic [CH_W-1:0]        setup_ch;
		logic [7:0]             status;
		logic [6:0]             d1;
		logic [6:0]             d2;
		logic                   len3;
		logic                   bad;
	} job_t;

	function automatic logic [6:0] ctl_map(input logic [7:0] idx);
		logic [6:0] r;
		case (idx)
			8'd0:    r = 7'h00;
			8'd1:    r = 7'h00;
			8'd2:    r = 7'h01;
			8'd3:    r = 7'h07;
			8'd4:    r = 7'h0A;
			8'd5:    r = 7'h0B;
			8'd6:    r = 7'h5B;
			8'd7:    r = 7'h5D;
			8'd8:    r = 7'h40;
			8'd9:    r = 7'h43;
			8'd10:   r = 7'h78;
			8'd11:   r = 7'h7B;
			8'd12:   r = 7'h7E;
			8'd13:   r = 7'h7F;
			8'd14:   r = 7'h79;
			default: r = 7'h00;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/mus_to_midi_event_transcoder.sv =====
// Top level: score byte parser, channel map memory and MIDI byte emitter.
// Order: stage 1 and the map read load at the transfer edge of an event's final score
// byte, the emitter loads the job when free, then the output reg takes the first byte.
// Throughput: one score byte per cycle while the emitter keeps up; an event is 3 to 11
// MIDI bytes, one per cycle without midi_stall, set by the single output byte register.
// Reset (arst_n low) clears parse state, channel map valid bits, the allocation counter,
// delays and output valid, and sets volumes to 64; map memory contents are not reset.
module mus_to_midi_event_transcoder
	import mtm_pkg::*;
#(
	parameter int DELTA_WIDTH = DELTA_W_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       score_valid,
	output logic       score_stall,
	input  logic [7:0] score_byte,
	input  logic       new_score,
	output logic       midi_valid,
	input  logic       midi_stall,
	output logic [7:0] midi_byte,
	output logic       last_of_event,
	output logic       bad_controller,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata
);

	localparam logic [DELTA_WIDTH-1:0] DMAX = '1;

	// ---------------- parse state ----------------
	logic [3:0]             pcc_q;
	phase_t                 phase_q, ph_eff, ph_n;
	logic [7:0]             hev_q, hev_eff, hev_n;
	logic [7:0]             hd_q, hd_eff, hd_n;
	logic [DELTA_WIDTH-1:0] pend_q, pend_eff, pend_n;
	logic [DELTA_WIDTH-1:0] carr_q, carr_eff, carr_n;
	logic [DELTA_WIDTH:0]   sum_w;
	logic [DELTA_WIDTH-1:0] sum_sat;
	logic [DELTA_WIDTH+6:0] shl_w;
	logic [DELTA_WIDTH-1:0] shl_sat;
	logic                   in_acc;

	// event descriptor built from the current byte
	logic            emit;
	logic [CH_W-1:0] ch_c;
	logic [7:0]      st_c;
	logic            or_ch_c, len3_c, bad_c, vsrc_c, vwr_c;
	logic [6:0]      d1_c, d2_c;

	// ---------------- stage 1 (map read) ----------------
	logic                   s1_valid_q, s1_load, s1_adv;
	logic [CH_W-1:0]        ch_s1;
	logic [7:0]             st_s1;
	logic                   or_ch_s1, len3_s1, bad_s1, vsrc_s1, vwr_s1;
	logic [6:0]             d1_s1, d2_s1;
	logic [DELTA_WIDTH-1:0] delta_s1;
	logic [CH_W-1:0]        map_rd_s1, fwd_data_s1;
	logic                   fwd_hit_s1;

	// ---------------- channel state ----------------
	logic [CH_W-1:0]     map_mem [CH_COUNT];
	logic [CH_COUNT-1:0] map_vld_q;
	logic [6:0]          vol_q [CH_COUNT];
	logic [4:0]          nfc_q, nfc_inc, nfc_n;
	logic                eff_vld, need_alloc, job_free;
	logic [CH_W-1:0]     mapped, m_c;
	job_t                job_c;

	assign in_acc      = score_valid && !score_stall;
	assign s1_adv      = s1_valid_q && job_free;
	assign score_stall = s1_valid_q && !job_free;
	assign s1_load     = in_acc && emit;

	// a new score clears the per-score parse state ahead of this byte
	assign ph_eff   = new_score ? PH_EVENT : phase_q;
	assign hev_eff  = new_score ? 8'h00 : hev_q;
	assign hd_eff   = new_score ? 8'h00 : hd_q;
	assign pend_eff = new_score ? '0 : pend_q;
	assign carr_eff = new_score ? '0 : carr_q;

	// saturating carry + pending delay
	assign sum_w   = {1'b0, carr_eff} + {1'b0, pend_eff};
	assign sum_sat = sum_w[DELTA_WIDTH] ? DMAX : sum_w[DELTA_WIDTH-1:0];
	// saturating 7-bit shift-in of a delay byte
	assign shl_w   = {pend_eff, score_byte[6:0]};
	assign shl_sat = (shl_w[DELTA_WIDTH+6:DELTA_WIDTH] != '0) ? DMAX :
		shl_w[DELTA_WIDTH-1:0];

	// parser
	always_comb begin
		ph_n    = ph_eff;
		hev_n   = hev_eff;
		hd_n    = hd_eff;
		pend_n  = pend_eff;
		carr_n  = carr_eff;
		emit    = 1'b0;
		ch_c    = hev_eff[3:0];
		st_c    = ST_NOTE_OFF;
		or_ch_c = 1'b1;
		len3_c  = 1'b1;
		bad_c   = 1'b0;
		vsrc_c  = 1'b0;
		vwr_c   = 1'b0;
		d1_c    = score_byte[6:0];
		d2_c    = '0;
		case (ph_eff)
			PH_EVENT: begin
				hev_n = score_byte;
				ch_c  = score_byte[3:0];
				case (score_byte[6:4])
					EV_SKIP_A, EV_SKIP_B: begin
						// skipped event: its delay rides on to the next output
						carr_n = sum_sat;
						pend_n = '0;
						ph_n   = score_byte[7] ? PH_DELAY : PH_EVENT;
					end
					EV_END: begin
						emit    = 1'b1;
						st_c    = ST_META;
						or_ch_c = 1'b0;
						d1_c    = META_EOT;
					end
					default: ph_n = PH_DATA1;
				endcase
			end
			PH_DATA1: begin
				case (hev_eff[6:4])
					EV_NOTE_OFF: begin
						emit = 1'b1;
						d2_c = OFF_VEL;
					end
					EV_NOTE_ON: begin
						if (score_byte[7]) begin
							hd_n = {1'b0, score_byte[6:0]};
							ph_n = PH_VOLUME;
						end else begin
							emit   = 1'b1;
							st_c   = ST_NOTE_ON;
							vsrc_c = 1'b1;
						end
					end
					EV_BEND: begin
						emit = 1'b1;
						st_c = ST_BEND;
						d1_c = {score_byte[0], 6'd0};
						d2_c = score_byte[7:1];
					end
					EV_MODE: begin
						emit  = 1'b1;
						st_c  = ST_CTRL;
						bad_c = score_byte > CTL_LAST;
						d1_c  = ctl_map(score_byte);
						d2_c  = (score_byte == CTL_MONO) ? (7'(pcc_q) + 7'd1) : 7'd0;
					end
					default: begin
						hd_n = score_byte;
						ph_n = PH_DATA2;
					end
				endcase
			end
			PH_VOLUME: begin
				emit  = 1'b1;
				st_c  = ST_NOTE_ON;
				d1_c  = hd_eff[6:0];
				d2_c  = score_byte[6:0];
				vwr_c = 1'b1;
			end
			PH_DATA2: begin
				emit = 1'b1;
				if (hd_eff == 8'h00) begin
					st_c   = ST_PROG;
					len3_c = 1'b0;
				end else begin
					st_c  = ST_CTRL;
					bad_c = hd_eff > CTL_LAST;
					d1_c  = ctl_map(hd_eff);
					d2_c  = score_byte[6:0];
				end
			end
			PH_DELAY: begin
				pend_n = shl_sat;
				if (!score_byte[7]) ph_n = PH_EVENT;
			end
			default: ph_n = PH_EVENT;
		endcase
		if (emit) begin
			pend_n = '0;
			carr_n = '0;
			ph_n   = hev_n[7] ? PH_DELAY : PH_EVENT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcc_q      <= '0;
			phase_q    <= PH_EVENT;
			hev_q      <= '0;
			hd_q       <= '0;
			pend_q     <= '0;
			carr_q     <= '0;
			s1_valid_q <= 1'b0;
			fwd_hit_s1 <= 1'b0;
		end else begin
			if (cfg_we) pcc_q <= cfg_wdata;
			if (in_acc) begin
				phase_q <= ph_n;
				hev_q   <= hev_n;
				hd_q    <= hd_n;
				pend_q  <= pend_n;
				carr_q  <= carr_n;
			end
			if (s1_load) s1_valid_q <= 1'b1;
			else if (s1_adv) s1_valid_q <= 1'b0;
			// map write and read of the same entry in one cycle: forward
			if (s1_load) fwd_hit_s1 <= s1_adv && need_alloc && (ch_s1 == ch_c);
		end
	end

	// stage 1 payload and the synchronous map memory
	always_ff @(posedge clk) begin
		if (s1_load) begin
			ch_s1       <= ch_c;
			st_s1       <= st_c;
			or_ch_s1    <= or_ch_c;
			len3_s1     <= len3_c;
			bad_s1      <= bad_c;
			vsrc_s1     <= vsrc_c;
			vwr_s1      <= vwr_c;
			d1_s1       <= d1_c;
			d2_s1       <= d2_c;
			delta_s1    <= sum_sat;
			map_rd_s1   <= map_mem[ch_c];
			fwd_data_s1 <= m_c;
		end
		if (s1_adv && need_alloc) map_mem[ch_s1] <= m_c;
	end

	// ---------------- stage 2: channel resolve / allocate ----------------
	// score channel 15 is fixed to the percussion channel
	assign eff_vld    = map_vld_q[ch_s1] || (ch_s1 == PERC_SRC);
	assign need_alloc = !eff_vld;
	assign mapped     = (ch_s1 == PERC_SRC) ? PERC_CH :
		(fwd_hit_s1 ? fwd_data_s1 : map_rd_s1);
	assign m_c        = eff_vld ? mapped : nfc_q[3:0];
	assign nfc_inc    = (nfc_q != CH_LIMIT) ? (nfc_q + 5'd1) : nfc_q;
	assign nfc_n      = (nfc_inc == SKIP_CH) ? (nfc_inc + 5'd1) : nfc_inc;

	always_comb begin
		job_c          = '0;
		job_c.delta    = DELTA_W_MAX'(delta_s1);
		job_c.setup    = need_alloc;
		job_c.setup_ch = m_c;
		job_c.status   = or_ch_s1 ? {st_s1[7:4], m_c} : st_s1;
		job_c.d1       = d1_s1;
		job_c.d2       = vsrc_s1 ? vol_q[m_c] : d2_s1;
		job_c.len3     = len3_s1;
		job_c.bad      = bad_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_vld_q <= '0;
			nfc_q     <= '0;
			for (int i = 0; i < CH_COUNT; i++) vol_q[i] <= VOL_RESET;
		end else if (in_acc && new_score) begin
			// the event in stage 1 precedes this byte, so the clear wins
			map_vld_q <= '0;
			nfc_q     <= '0;
			for (int i = 0; i < CH_COUNT; i++) vol_q[i] <= VOL_RESET;
		end else if (s1_adv) begin
			if (need_alloc) begin
				map_vld_q[ch_s1] <= 1'b1;
				nfc_q            <= nfc_n;
			end
			if (vwr_s1) vol_q[m_c] <= d2_s1;
		end
	end

	mtm_emit #(
		.DELTA_WIDTH(DELTA_WIDTH)
	) u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_load      (s1_adv),
		.job           (job_c),
		.job_free      (job_free),
		.midi_valid    (midi_valid),
		.midi_stall    (midi_stall),
		.midi_byte     (midi_byte),
		.last_of_event (last_of_event),
		.bad_controller(bad_controller)
	);

endmodule

// ===== sv/mtm_emit.sv =====
// Byte sequencer: turns one event job into delta, setup and message bytes.
module mtm_emit
	import mtm_pkg::*;
#(
	parameter int DELTA_WIDTH = DELTA_W_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_load,
	input  job_t       job,
	output logic       job_free,
	output logic       midi_valid,
	input  logic       midi_stall,
	output logic [7:0] midi_byte,
	output logic       last_of_event,
	output logic       bad_controller
);

	localparam int GROUPS = (DELTA_WIDTH + 6) / 7;
	localparam int GIW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;

	logic           act_q;
	seq_t           sq_q, sq_n;
	logic [GIW-1:0] grp_q, grp_n, grp_top;
	logic [1:0]     cnt_q, cnt_n;
	job_t           job_q;
	logic           out_load, last_c;
	logic [7:0]     byte_c;
	logic [6:0]     grp_bits;

	assign out_load = act_q && (!midi_valid || !midi_stall);
	assign job_free = !act_q || (out_load && last_c);
	assign grp_bits = 7'(job_q.delta >> (7 * grp_q));

	// top VLQ group index of the new job's delta
	always_comb begin
		grp_top = '0;
		for (int i = 1; i < GROUPS; i++) begin
			if ((job.delta >> (7 * i)) != '0) grp_top = GIW'(i);
		end
	end

	// byte selection
	always_comb begin
		byte_c = '0;
		last_c = 1'b0;
		case (sq_q)
			SQ_DELTA: byte_c = {(grp_q != '0), grp_bits};
			SQ_SETUP: begin
				case (cnt_q)
					2'd0:    byte_c = ST_CTRL | {4'h0, job_q.setup_ch};
					2'd1:    byte_c = {1'b0, CC_VOLUME};
					2'd2:    byte_c = {1'b0, VOL_FULL};
					default: byte_c = 8'h00;
				endcase
			end
			SQ_MSG: begin
				case (cnt_q)
					2'd0:    byte_c = job_q.status;
					2'd1:    byte_c = {1'b0, job_q.d1};
					default: byte_c = {1'b0, job_q.d2};
				endcase
				last_c = (cnt_q == (job_q.len3 ? 2'd2 : 2'd1));
			end
			default: byte_c = '0;
		endcase
	end

	// next position
	always_comb begin
		sq_n  = sq_q;
		grp_n = grp_q;
		cnt_n = cnt_q;
		case (sq_q)
			SQ_DELTA: begin
				if (grp_q == '0) begin
					sq_n  = job_q.setup ? SQ_SETUP : SQ_MSG;
					cnt_n = '0;
				end else begin
					grp_n = grp_q - 1'b1;
				end
			end
			SQ_SETUP: begin
				cnt_n = cnt_q + 1'b1;
				if (cnt_q == 2'd3) sq_n = SQ_MSG;
			end
			SQ_MSG:   cnt_n = cnt_q + 1'b1;
			default:  sq_n = SQ_DELTA;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q      <= 1'b0;
			sq_q       <= SQ_DELTA;
			grp_q      <= '0;
			cnt_q      <= '0;
			midi_valid <= 1'b0;
		end else begin
			if (job_load) begin
				act_q <= 1'b1;
				sq_q  <= SQ_DELTA;
				grp_q <= grp_top;
				cnt_q <= '0;
			end else if (out_load) begin
				if (last_c) act_q <= 1'b0;
				sq_q  <= sq_n;
				grp_q <= grp_n;
				cnt_q <= cnt_n;
			end
			if (out_load) midi_valid <= 1'b1;
			else if (!midi_stall) midi_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_load) job_q <= job;
		if (out_load) begin
			midi_byte      <= byte_c;
			last_of_event  <= last_c;
			bad_controller <= job_q.bad;
		end
	end

endmodule

// ===== sv/mtm_checker.sv =====
// Port-level checks on the transcoder output stream, bound to the top level.
module mtm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       midi_valid,
	input logic       midi_stall,
	input logic [7:0] midi_byte,
	input logic       last_of_event,
	input logic       bad_controller
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		midi_valid && midi_stall |=> midi_valid)
		else $error("output valid dropped while stalled");

	a_hold_byte: assert property (@(posedge clk) disable iff (!arst_n)
		midi_valid && midi_stall |=> $stable(midi_byte))
		else $error("output byte changed while stalled");

	a_event_runs: assert property (@(posedge clk) disable iff (!arst_n)
		midi_valid && !midi_stall && !last_of_event |=> midi_valid)
		else $error("gap inside an event's byte run");

	a_bad_flag_steady: assert property (@(posedge clk) disable iff (!arst_n)
		midi_valid && !midi_stall && !last_of_event |=>
		bad_controller == $past(bad_controller))
		else $error("bad_controller changed within an event");

endmodule

bind mus_to_midi_event_transcoder mtm_checker u_mtm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.midi_valid    (midi_valid),
	.midi_stall    (midi_stall),
	.midi_byte     (midi_byte),
	.last_of_event (last_of_event),
	.bad_controller(bad_controller)
);
